@@ design/ohvs_pkg.sv @@
// Package: sizes, codes and shared types of the oldest-or-highest-value server.
`timescale 1ns / 1ps

package ohvs_pkg;

  localparam int CAPACITY     = 1024;
  localparam int NUMBER_WIDTH = 20;
  localparam int AMOUNT_WIDTH = 19;
  localparam int SLOT_WIDTH   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ENTRY_WIDTH  = AMOUNT_WIDTH + 1;
  localparam int IN_DATA_W    = ((AMOUNT_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((NUMBER_WIDTH + 7) / 8) * 8;
  localparam int CMD_WIDTH    = 2;
  localparam int STATUS_WIDTH = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ARRIVE        = 2'd0,
    CMD_SERVE_OLDEST  = 2'd1,
    CMD_SERVE_HIGHEST = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_SERVED  = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_REFUSED = 2'd2
  } status_e;

  typedef struct packed {
    logic                    waiting;
    logic [AMOUNT_WIDTH-1:0] amount;
  } entry_t;

  typedef struct packed {
    logic arrive;
    logic refuse;
    logic report_empty;
    logic serve_oldest;
    logic scan_start;
    logic scan_run;
    logic pick;
    logic adv_read;
    logic adv_step;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic scan_done;
    logic chosen_is_oldest;
    logic head_waiting;
  } dp_status_t;

endpackage

@@ design/ohvs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ohvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/ohvs_ctrl.sv @@
// Controller state machine: command decode, scan and oldest-pointer sequencing.
`timescale 1ns / 1ps

module ohvs_ctrl import ohvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  cmd_e       in_cmd_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_ADV_RD  = 4'b0100,
    S_ADV_CHK = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            CMD_ARRIVE: begin
              if (status_i.full) begin
                cmd_o.refuse = 1'b1;
              end else begin
                cmd_o.arrive = 1'b1;
              end
            end
            CMD_SERVE_OLDEST: begin
              if (status_i.empty) begin
                cmd_o.report_empty = 1'b1;
              end else begin
                cmd_o.serve_oldest = 1'b1;
                state_d            = S_ADV_RD;
              end
            end
            CMD_SERVE_HIGHEST: begin
              if (status_i.empty) begin
                cmd_o.report_empty = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.pick = 1'b1;
          state_d    = status_i.chosen_is_oldest ? S_ADV_RD : S_IDLE;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      S_ADV_RD: begin
        if (status_i.empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.adv_read = 1'b1;
          state_d        = S_ADV_CHK;
        end
      end
      S_ADV_CHK: begin
        if (status_i.head_waiting) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.adv_step = 1'b1;
          state_d        = S_ADV_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/ohvs_datapath.sv @@
// Datapath: number window, entry store, max scan and result register.
`timescale 1ns / 1ps

module ohvs_datapath import ohvs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic [AMOUNT_WIDTH-1:0] amount_i,
  input  logic                    out_ready_i,
  output dp_status_t              status_o,
  output logic                    out_valid_o,
  output logic [NUMBER_WIDTH-1:0] out_number_o,
  output status_e                 out_status_o
);

  localparam int CmpW = 33;

  logic [NUMBER_WIDTH-1:0] next_q, next_d, oldest_q, oldest_d;
  logic [SLOT_WIDTH-1:0]   next_slot_q, next_slot_d, oldest_slot_q, oldest_slot_d;
  logic [NUMBER_WIDTH-1:0] scan_num_q, scan_num_d, cmp_num_q, best_num_q;
  logic [SLOT_WIDTH-1:0]   scan_slot_q, scan_slot_d, cmp_slot_q, best_slot_q;
  logic [AMOUNT_WIDTH-1:0] best_amt_q;
  logic                    cmp_valid_q, cmp_valid_d, best_valid_q, best_valid_d;
  logic                    out_valid_q, out_valid_d;
  logic [NUMBER_WIDTH-1:0] out_number_q;
  status_e                 out_status_q;

  logic [NUMBER_WIDTH-1:0] window;
  logic                    issue_done, issue, better, load_out;
  logic                    ram_we, ram_re;
  logic [SLOT_WIDTH-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_WIDTH-1:0]  ram_wdata, ram_rdata;
  entry_t                  rd_entry, wr_entry;

  function automatic logic [SLOT_WIDTH-1:0] slot_inc(input logic [SLOT_WIDTH-1:0] s);
    slot_inc = (s == SLOT_WIDTH'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  assign window     = next_q - oldest_q;
  assign issue_done = (scan_num_q == next_q);
  assign issue      = cmd_i.scan_run && !issue_done;
  assign rd_entry   = entry_t'(ram_rdata);
  assign better     = cmp_valid_q && rd_entry.waiting &&
                      (!best_valid_q || (rd_entry.amount > best_amt_q));

  assign status_o.full = ({{(CmpW-NUMBER_WIDTH){1'b0}}, window} >= CmpW'(CAPACITY)) ||
                         (next_q == {NUMBER_WIDTH{1'b1}});
  assign status_o.empty            = (oldest_q == next_q);
  assign status_o.out_free         = !out_valid_q || out_ready_i;
  assign status_o.scan_done        = issue_done && !cmp_valid_q;
  assign status_o.chosen_is_oldest = (best_num_q == oldest_q);
  assign status_o.head_waiting     = rd_entry.waiting;

  // Store entry on arrival, drop the waiting flag on serve.
  always_comb begin
    wr_entry.waiting = cmd_i.arrive;
    wr_entry.amount  = cmd_i.arrive ? amount_i : '0;
  end
  assign ram_we    = cmd_i.arrive || cmd_i.serve_oldest || cmd_i.pick;
  assign ram_wdata = wr_entry;
  assign ram_waddr = cmd_i.arrive       ? next_slot_q   :
                     cmd_i.serve_oldest ? oldest_slot_q : best_slot_q;
  assign ram_re    = issue || cmd_i.adv_read;
  assign ram_raddr = cmd_i.adv_read ? oldest_slot_q : scan_slot_q;

  ohvs_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    next_d        = next_q;
    next_slot_d   = next_slot_q;
    oldest_d      = oldest_q;
    oldest_slot_d = oldest_slot_q;
    scan_num_d    = scan_num_q;
    scan_slot_d   = scan_slot_q;
    cmp_valid_d   = 1'b0;
    best_valid_d  = best_valid_q;
    if (cmd_i.arrive) begin
      next_d      = next_q + 1'b1;
      next_slot_d = slot_inc(next_slot_q);
    end
    if (cmd_i.serve_oldest || cmd_i.adv_step ||
        (cmd_i.pick && status_o.chosen_is_oldest)) begin
      oldest_d      = oldest_q + 1'b1;
      oldest_slot_d = slot_inc(oldest_slot_q);
    end
    if (cmd_i.scan_start) begin
      scan_num_d   = oldest_q;
      scan_slot_d  = oldest_slot_q;
      best_valid_d = 1'b0;
    end
    if (issue) begin
      scan_num_d  = scan_num_q + 1'b1;
      scan_slot_d = slot_inc(scan_slot_q);
      cmp_valid_d = 1'b1;
    end
    if (better) begin
      best_valid_d = 1'b1;
    end
  end

  assign load_out = cmd_i.refuse || cmd_i.report_empty || cmd_i.serve_oldest || cmd_i.pick;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q        <= NUMBER_WIDTH'(1);
      next_slot_q   <= SLOT_WIDTH'(1 % CAPACITY);
      oldest_q      <= NUMBER_WIDTH'(1);
      oldest_slot_q <= SLOT_WIDTH'(1 % CAPACITY);
      cmp_valid_q   <= 1'b0;
      best_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      next_q        <= next_d;
      next_slot_q   <= next_slot_d;
      oldest_q      <= oldest_d;
      oldest_slot_q <= oldest_slot_d;
      cmp_valid_q   <= cmp_valid_d;
      best_valid_q  <= best_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_num_q  <= scan_num_d;
    scan_slot_q <= scan_slot_d;
    if (issue) begin
      cmp_num_q  <= scan_num_q;
      cmp_slot_q <= scan_slot_q;
    end
    if (better) begin
      best_num_q  <= cmp_num_q;
      best_slot_q <= cmp_slot_q;
      best_amt_q  <= rd_entry.amount;
    end
    if (load_out) begin
      priority if (cmd_i.refuse) begin
        out_number_q <= '0;
        out_status_q <= STATUS_REFUSED;
      end else if (cmd_i.report_empty) begin
        out_number_q <= '0;
        out_status_q <= STATUS_EMPTY;
      end else if (cmd_i.serve_oldest) begin
        out_number_q <= oldest_q;
        out_status_q <= STATUS_SERVED;
      end else begin
        out_number_q <= best_num_q;
        out_status_q <= STATUS_SERVED;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_number_o = out_number_q;
  assign out_status_o = out_status_q;

endmodule

@@ design/oldest_or_highest_value_server_core.sv @@
// Top level of the oldest-or-highest-value server: controller, datapath, checks.
//
//  channel  | dir | tdata                         | tuser
//  s_axis   | in  | [18:0] amount, [23:19] zero   | [1:0] cmd
//  m_axis   | out | [19:0] served_number, [23:20] 0 | [1:0] status
//
// Arrival, refusal, cmd 3 and serving with nothing waiting finish at acceptance.
// Serve-oldest: after the result is loaded, the oldest pointer skips each non-waiting
// number with one store read and check, until a waiting one or an empty store is found.
// Serve-highest: one store read per entry of the window, through the single read port
// and one comparator; when the oldest entry is taken, the pointer advance follows as for
// serve-oldest.
// Reset sets pointers to 1, clears control; no clearing pass, flags read only in the window.
// s_axis_tready stays low while an item is at work or a result waits untaken.
`timescale 1ns / 1ps

module oldest_or_highest_value_server_core import ohvs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // [18:0] amount
  input  logic [CMD_WIDTH-1:0]    s_axis_tuser,   // [1:0] cmd
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [19:0] served_number
  output logic [STATUS_WIDTH-1:0] m_axis_tuser    // [1:0] status
);

  dp_cmd_t                 dp_cmd;
  dp_status_t              dp_status;
  logic [NUMBER_WIDTH-1:0] out_number;
  status_e                 out_status;

  ohvs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_cmd_i  (cmd_e'(s_axis_tuser)),
    .status_i  (dp_status),
    .in_ready_o(s_axis_tready),
    .cmd_o     (dp_cmd)
  );

  ohvs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .amount_i    (s_axis_tdata[AMOUNT_WIDTH-1:0]),
    .out_ready_i (m_axis_tready),
    .status_o    (dp_status),
    .out_valid_o (m_axis_tvalid),
    .out_number_o(out_number),
    .out_status_o(out_status)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-NUMBER_WIDTH){1'b0}}, out_number};
  assign m_axis_tuser = out_status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.arrive, dp_cmd.refuse, dp_cmd.report_empty, dp_cmd.serve_oldest,
              dp_cmd.scan_start, dp_cmd.scan_run, dp_cmd.pick, dp_cmd.adv_read,
              dp_cmd.adv_step}))
    else $error("more than one datapath command at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_status == STATUS_SERVED) == (out_number != '0)))
    else $error("served number does not match status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_ARRIVE) && !dp_status.full)
    |=> !m_axis_tvalid)
    else $error("stored arrival produced a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.pick |-> !m_axis_tvalid)
    else $error("scan result would overwrite a pending result");

endmodule
